[hdl/rbfs_pkg.sv]
package rbfs_pkg;

   localparam int TICK_W  = 10;
   localparam int INDEX_W = 3;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_DEBOUNCE = 4'd1,
      PH_LEAD     = 4'd2,
      PH_TAIL     = 4'd3,
      PH_SETTLE   = 4'd4,
      PH_LONG     = 4'd5,
      PH_HOLD     = 4'd6
   } phase_type;

   localparam logic [INDEX_W-1:0] CSR_DEBOUNCE   = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_FET_LEAD   = 3'd1;
   localparam logic [INDEX_W-1:0] CSR_FET_TAIL   = 3'd2;
   localparam logic [INDEX_W-1:0] CSR_SETTLE     = 3'd3;
   localparam logic [INDEX_W-1:0] CSR_LONG_PRESS = 3'd4;

   localparam logic [TICK_W-1:0] DEBOUNCE_RST   = 10'd15;
   localparam logic [TICK_W-1:0] FET_LEAD_RST   = 10'd20;
   localparam logic [TICK_W-1:0] FET_TAIL_RST   = 10'd20;
   localparam logic [TICK_W-1:0] SETTLE_RST     = 10'd10;
   localparam logic [TICK_W-1:0] LONG_PRESS_RST = 10'd250;

   typedef struct packed {
      logic [TICK_W-1:0] debounce_ticks;
      logic [TICK_W-1:0] fet_lead_ticks;
      logic [TICK_W-1:0] fet_tail_ticks;
      logic [TICK_W-1:0] settle_ticks;
      logic [TICK_W-1:0] long_press_ticks;
   } tick_cfg_type;

   typedef struct packed {
      logic relay_drive;
      logic photofet_drive;
      logic busy_res;
   } drive_type;

endpackage

[hdl/relay_bypass_footswitch_sequencer_core.sv]
// relay bypass footswitch sequencer
//
// req channel: one word per millisecond tick, req_tdata[0] is the footswitch
// level (1 = pressed). rsp channel: one word per accepted tick, carrying the
// drive levels after that tick: relay/LED drive, photofet mute drive, busy.
// csr port: csr_we writes csr_wdata into the timing register at csr_index
// (0 debounce, 1 fet lead, 2 fet tail, 3 settle, 4 long press); other
// indexes are ignored. write only while no tick is in flight.
//
// the tick's state update happens at acceptance and the result sits in the
// output register on the next cycle. throughput is one tick per cycle; the
// whole state update is a single pass through the phase/counter logic.
// req_tready is high whenever the output register is empty or being emptied,
// so a stalled receiver holds the result and stalls the req side only while
// it holds.
// reset clears the phase, counter and drives (effect off) and loads the
// timing registers with 15, 20, 20, 10 and 250 ticks.
module relay_bypass_footswitch_sequencer_core #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [0] switch_pressed
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [0] relay_drive,
                                                          // [1] photofet_drive, [2] busy_res
   input  logic                              csr_we,
   input  logic [rbfs_pkg::INDEX_W-1:0]      csr_index,
   input  logic [rbfs_pkg::TICK_W-1:0]       csr_wdata
);

   rbfs_pkg::tick_cfg_type cfg;
   rbfs_pkg::drive_type    drive;
   rbfs_pkg::drive_type    rsp_word_ff;
   logic                   rsp_valid_ff;
   logic                   req_take;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   rbfs_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rbfs_fsm #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (req_take),
      .pressed (req_tdata[0]),
      .cfg     (cfg),
      .drive   (drive)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_word_ff <= drive;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_word_ff.busy_res, rsp_word_ff.photofet_drive,
                        rsp_word_ff.relay_drive};

endmodule

[hdl/rbfs_cfg.sv]
module rbfs_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rbfs_pkg::INDEX_W-1:0]        csr_index,
   input  logic [rbfs_pkg::TICK_W-1:0]         csr_wdata,
   output rbfs_pkg::tick_cfg_type              cfg
);

   rbfs_pkg::tick_cfg_type cfg_ff;
   rbfs_pkg::tick_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            rbfs_pkg::CSR_DEBOUNCE:   cfg_in.debounce_ticks   = csr_wdata;
            rbfs_pkg::CSR_FET_LEAD:   cfg_in.fet_lead_ticks   = csr_wdata;
            rbfs_pkg::CSR_FET_TAIL:   cfg_in.fet_tail_ticks   = csr_wdata;
            rbfs_pkg::CSR_SETTLE:     cfg_in.settle_ticks     = csr_wdata;
            rbfs_pkg::CSR_LONG_PRESS: cfg_in.long_press_ticks = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= rbfs_pkg::DEBOUNCE_RST;
         cfg_ff.fet_lead_ticks   <= rbfs_pkg::FET_LEAD_RST;
         cfg_ff.fet_tail_ticks   <= rbfs_pkg::FET_TAIL_RST;
         cfg_ff.settle_ticks     <= rbfs_pkg::SETTLE_RST;
         cfg_ff.long_press_ticks <= rbfs_pkg::LONG_PRESS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/rbfs_fsm.sv]
module rbfs_fsm #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic                    pressed,
   input  rbfs_pkg::tick_cfg_type  cfg,
   output rbfs_pkg::drive_type     drive
);

   localparam int TW = rbfs_pkg::TICK_W;

   rbfs_pkg::phase_type     phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]  wait_count_ff, wait_count_in;
   logic                    effect_on_ff, effect_on_in;
   logic                    fet_on_ff, fet_on_in;
   logic                    second_ff, second_in;

   logic                    cnt_zero;
   logic                    advance;
   logic [TW-1:0]           load_sel;
   logic [COUNT_WIDTH-1:0]  load_val;
   logic                    load_phase;

   assign cnt_zero = (wait_count_ff == '0);

   // idle and hold move on the switch level, the timed phases on an expired count
   always_comb begin
      case (phase_ff)
         rbfs_pkg::PH_IDLE: advance = pressed;
         rbfs_pkg::PH_HOLD: advance = !pressed;
         default:           advance = cnt_zero;
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         unique case (phase_ff)
            rbfs_pkg::PH_IDLE:     phase_in = rbfs_pkg::PH_DEBOUNCE;
            rbfs_pkg::PH_HOLD:     phase_in = rbfs_pkg::PH_LEAD;
            rbfs_pkg::PH_DEBOUNCE: phase_in = pressed ? rbfs_pkg::PH_LEAD
                                                      : rbfs_pkg::PH_LONG;
            rbfs_pkg::PH_LEAD:     phase_in = rbfs_pkg::PH_TAIL;
            rbfs_pkg::PH_TAIL:     phase_in = rbfs_pkg::PH_SETTLE;
            rbfs_pkg::PH_SETTLE:   phase_in = second_ff ? rbfs_pkg::PH_IDLE
                                                        : rbfs_pkg::PH_LONG;
            rbfs_pkg::PH_LONG:     phase_in = pressed ? rbfs_pkg::PH_HOLD
                                                      : rbfs_pkg::PH_IDLE;
            default:               phase_in = rbfs_pkg::PH_IDLE;
         endcase
      end
   end

   // the wait length follows from the phase being entered
   always_comb begin
      load_phase = 1'b1;
      case (phase_in)
         rbfs_pkg::PH_DEBOUNCE: load_sel = cfg.debounce_ticks;
         rbfs_pkg::PH_LEAD:     load_sel = cfg.fet_lead_ticks;
         rbfs_pkg::PH_TAIL:     load_sel = cfg.fet_tail_ticks;
         rbfs_pkg::PH_SETTLE:   load_sel = cfg.settle_ticks;
         rbfs_pkg::PH_LONG:     load_sel = cfg.long_press_ticks;
         default: begin
            load_sel   = '0;
            load_phase = 1'b0;
         end
      endcase
   end

   generate
      if (COUNT_WIDTH >= TW) begin : g_wide
         assign load_val = COUNT_WIDTH'(load_sel);
      end else begin : g_narrow
         // saturate when the register outgrows the counter
         assign load_val = (|load_sel[TW-1:COUNT_WIDTH]) ? '1
                                                         : load_sel[COUNT_WIDTH-1:0];
      end
   endgenerate

   // counter and drive flags
   always_comb begin
      wait_count_in = wait_count_ff;
      effect_on_in  = effect_on_ff;
      fet_on_in     = fet_on_ff;
      second_in     = second_ff;
      if (advance) begin
         wait_count_in = load_phase ? load_val : '0;
         case (phase_ff)
            rbfs_pkg::PH_HOLD: begin
               fet_on_in = 1'b1;
               second_in = 1'b1;
            end
            rbfs_pkg::PH_DEBOUNCE: begin
               if (pressed) fet_on_in = 1'b1;
            end
            rbfs_pkg::PH_LEAD:   effect_on_in = !effect_on_ff;
            rbfs_pkg::PH_TAIL:   fet_on_in    = 1'b0;
            rbfs_pkg::PH_SETTLE: second_in    = 1'b0;
            default: ;
         endcase
      end else if (phase_ff != rbfs_pkg::PH_IDLE && phase_ff != rbfs_pkg::PH_HOLD) begin
         wait_count_in = wait_count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= rbfs_pkg::PH_IDLE;
         wait_count_ff <= '0;
         effect_on_ff  <= 1'b0;
         fet_on_ff     <= 1'b0;
         second_ff     <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         wait_count_ff <= wait_count_in;
         effect_on_ff  <= effect_on_in;
         fet_on_ff     <= fet_on_in;
         second_ff     <= second_in;
      end
   end

   assign drive.relay_drive    = effect_on_in;
   assign drive.photofet_drive = fet_on_in;
   assign drive.busy_res       = (phase_in != rbfs_pkg::PH_IDLE);

`ifndef ASSERT_OFF
   a_relay_only_after_lead: assert property (@(posedge clock) disable iff (reset)
      (effect_on_ff != $past(effect_on_ff)) |-> ($past(phase_ff) == rbfs_pkg::PH_LEAD))
      else $error("relay switched outside the lead phase");

   a_fet_off_when_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rbfs_pkg::PH_IDLE) |-> !fet_on_ff)
      else $error("photofet left on in idle");

   a_second_in_sequence: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> (phase_ff == rbfs_pkg::PH_LEAD || phase_ff == rbfs_pkg::PH_TAIL
                     || phase_ff == rbfs_pkg::PH_SETTLE))
      else $error("second toggle flag outside a muting sequence");

   a_count_clear_untimed: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == rbfs_pkg::PH_IDLE || phase_ff == rbfs_pkg::PH_HOLD)
      |-> (wait_count_ff == '0))
      else $error("wait count live in an untimed phase");
`endif

endmodule

[bench/relay_bypass_footswitch_sequencer_core_tb.sv]
module relay_bypass_footswitch_sequencer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TW = rbfs_pkg::TICK_W;
   localparam int IW = rbfs_pkg::INDEX_W;

   localparam int unsigned CYCLE_LIMIT = 400000;
   // tick levels of the directed part, tick 0 in bit 0
   localparam logic [23:0] DIRECTED_LEVELS = 24'b0011_1101_1111_1101_1011_0010;

   // predicts the drive levels after every tick and holds them until they come out
   class drive_scoreboard;
      rbfs_pkg::tick_cfg_type timing;
      rbfs_pkg::phase_type    phase;
      logic [TW-1:0]          wait_count;
      bit                     effect_on;
      bit                     fet_on;
      bit                     second_toggle;
      rbfs_pkg::drive_type    drive_q[$];
      int unsigned            errors;
      int unsigned            checked;
      int unsigned            toggles;
      int unsigned            momentary;

      function new();
         timing = '{rbfs_pkg::DEBOUNCE_RST, rbfs_pkg::FET_LEAD_RST, rbfs_pkg::FET_TAIL_RST,
                    rbfs_pkg::SETTLE_RST, rbfs_pkg::LONG_PRESS_RST};
         phase = rbfs_pkg::PH_IDLE;
         wait_count = '0;
         effect_on = 1'b0;
         fet_on = 1'b0;
         second_toggle = 1'b0;
      endfunction

      function void set_reg(logic [IW-1:0] index, logic [TW-1:0] value);
         case (index)
            rbfs_pkg::CSR_DEBOUNCE:   timing.debounce_ticks = value;
            rbfs_pkg::CSR_FET_LEAD:   timing.fet_lead_ticks = value;
            rbfs_pkg::CSR_FET_TAIL:   timing.fet_tail_ticks = value;
            rbfs_pkg::CSR_SETTLE:     timing.settle_ticks = value;
            rbfs_pkg::CSR_LONG_PRESS: timing.long_press_ticks = value;
            default: ;
         endcase
      endfunction

      function void enter_wait(rbfs_pkg::phase_type next_phase, logic [TW-1:0] ticks);
         phase = next_phase;
         wait_count = ticks;
      endfunction

      function void note_tick(bit pressed);
         rbfs_pkg::drive_type d;
         if (phase == rbfs_pkg::PH_IDLE) begin
            if (pressed) enter_wait(rbfs_pkg::PH_DEBOUNCE, timing.debounce_ticks);
         end else if (phase == rbfs_pkg::PH_HOLD) begin
            // release after a long press: toggle back
            if (!pressed) begin
               second_toggle = 1'b1;
               fet_on = 1'b1;
               momentary++;
               enter_wait(rbfs_pkg::PH_LEAD, timing.fet_lead_ticks);
            end
         end else if (wait_count != 0) begin
            wait_count--;
         end else begin
            case (phase)
               rbfs_pkg::PH_DEBOUNCE: begin
                  if (pressed) begin
                     fet_on = 1'b1;
                     enter_wait(rbfs_pkg::PH_LEAD, timing.fet_lead_ticks);
                  end else begin
                     enter_wait(rbfs_pkg::PH_LONG, timing.long_press_ticks);
                  end
               end
               rbfs_pkg::PH_LEAD: begin
                  effect_on = !effect_on;
                  toggles++;
                  enter_wait(rbfs_pkg::PH_TAIL, timing.fet_tail_ticks);
               end
               rbfs_pkg::PH_TAIL: begin
                  fet_on = 1'b0;
                  enter_wait(rbfs_pkg::PH_SETTLE, timing.settle_ticks);
               end
               rbfs_pkg::PH_SETTLE: begin
                  if (second_toggle) begin
                     second_toggle = 1'b0;
                     enter_wait(rbfs_pkg::PH_IDLE, '0);
                  end else begin
                     enter_wait(rbfs_pkg::PH_LONG, timing.long_press_ticks);
                  end
               end
               rbfs_pkg::PH_LONG: begin
                  if (pressed) enter_wait(rbfs_pkg::PH_HOLD, '0);
                  else enter_wait(rbfs_pkg::PH_IDLE, '0);
               end
               default: enter_wait(rbfs_pkg::PH_IDLE, '0);
            endcase
         end
         d.relay_drive = effect_on;
         d.photofet_drive = fet_on;
         d.busy_res = (phase != rbfs_pkg::PH_IDLE);
         drive_q.push_back(d);
      endfunction

      function void check_word(logic [7:0] word);
         rbfs_pkg::drive_type d;
         if (drive_q.size() == 0) begin
            $error("result word %h with no tick waiting", word);
            errors++;
            return;
         end
         d = drive_q.pop_front();
         checked++;
         if (word[0] !== d.relay_drive) begin
            $error("relay_drive: expected %b, got %b", d.relay_drive, word[0]);
            errors++;
         end
         if (word[1] !== d.photofet_drive) begin
            $error("photofet_drive: expected %b, got %b", d.photofet_drive, word[1]);
            errors++;
         end
         if (word[2] !== d.busy_res) begin
            $error("busy_res: expected %b, got %b", d.busy_res, word[2]);
            errors++;
         end
         if (word[7:3] !== 5'd0) begin
            $error("padding: expected %b, got %b", 5'd0, word[7:3]);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return drive_q.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;
   logic                csr_we = 1'b0;
   logic [IW-1:0]       csr_index = '0;
   logic [TW-1:0]       csr_wdata = '0;

   drive_scoreboard board;
   int unsigned     cycles = 0;
   int unsigned     tx_gap_max = 0;
   int unsigned     rx_gap_max = 0;
   int unsigned     settings = 0;
   bit              held_off = 1'b0;

   relay_bypass_footswitch_sequencer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("relay_bypass_footswitch_sequencer_core: mismatch");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_tick(input bit pressed, input int unsigned gap);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, pressed};
      do @(posedge clock); while (!req_tready);
      board.note_tick(pressed);
      @(negedge clock);
   endtask

   task automatic put_reg(input logic [IW-1:0] index, input logic [TW-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      board.set_reg(index, value);
      @(negedge clock);
   endtask

   task automatic apply_timing(input rbfs_pkg::tick_cfg_type cfg);
      logic [IW-1:0] spare;
      // an index past the last register must be ignored
      spare = rbfs_pkg::CSR_LONG_PRESS + 3'd1 + 3'($urandom_range(0, 2));
      put_reg(rbfs_pkg::CSR_DEBOUNCE, cfg.debounce_ticks);
      put_reg(rbfs_pkg::CSR_FET_LEAD, cfg.fet_lead_ticks);
      put_reg(rbfs_pkg::CSR_FET_TAIL, cfg.fet_tail_ticks);
      put_reg(rbfs_pkg::CSR_SETTLE, cfg.settle_ticks);
      put_reg(rbfs_pkg::CSR_LONG_PRESS, cfg.long_press_ticks);
      put_reg(spare, TW'($urandom));
      csr_we <= 1'b0;
      settings++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (board.pending() != 0);
   endtask

   function automatic rbfs_pkg::tick_cfg_type rand_timing(input int unsigned hi);
      rbfs_pkg::tick_cfg_type cfg;
      cfg.debounce_ticks = TW'($urandom_range(0, hi));
      cfg.fet_lead_ticks = TW'($urandom_range(0, hi));
      cfg.fet_tail_ticks = TW'($urandom_range(0, hi));
      cfg.settle_ticks = TW'($urandom_range(0, hi));
      cfg.long_press_ticks = TW'($urandom_range(0, hi));
      return cfg;
   endfunction

   // press and release stretches sized against the whole sequence, with bounce bursts
   task automatic run_presses(input int unsigned count, input rbfs_pkg::tick_cfg_type cfg);
      bit          levels[$];
      int unsigned span;
      int unsigned n;
      span = cfg.debounce_ticks + cfg.fet_lead_ticks + cfg.fet_tail_ticks
           + cfg.settle_ticks + cfg.long_press_ticks + 6;
      while (levels.size() < count) begin
         if ($urandom_range(0, 9) < 2) begin
            n = $urandom_range(1, 6);
            repeat (n) levels.push_back(1'($urandom));
         end else begin
            n = $urandom_range(1, span + span / 2);
            repeat (n) levels.push_back(1'b1);
            n = $urandom_range(1, span);
            repeat (n) levels.push_back(1'b0);
         end
      end
      for (int i = 0; i < count; i++) send_tick(levels[i], $urandom_range(0, tx_gap_max));
   endtask

   initial begin
      wait (!reset);
      @(negedge clock);
      forever begin
         int unsigned stall;
         stall = $urandom_range(0, rx_gap_max);
         // one long hold-off so the output word backs up into the input
         if (!held_off && board.checked >= 400) begin
            held_off = 1'b1;
            stall = 64;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_word(rsp_tdata);
         @(negedge clock);
      end
   end

   initial begin
      rbfs_pkg::tick_cfg_type cfg;
      int unsigned            count;
      board = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero-length waits make every branch show up within a few ticks
      apply_timing('0);
      for (int i = 0; i < 24; i++) send_tick(DIRECTED_LEVELS[i], 0);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         count = 160;
         case (p)
            0: cfg = rand_timing(3);
            1: cfg = rand_timing(15);
            2: begin
               cfg = '{rbfs_pkg::DEBOUNCE_RST, rbfs_pkg::FET_LEAD_RST, rbfs_pkg::FET_TAIL_RST,
                       rbfs_pkg::SETTLE_RST, rbfs_pkg::LONG_PRESS_RST};
               count = 250;
            end
            3: begin
               cfg = rand_timing(6);
               cfg.long_press_ticks = TW'($urandom_range(0, 2));
            end
            4: cfg = rand_timing(30);
            default: begin
               cfg = '1;
               count = 1060;
            end
         endcase
         apply_timing(cfg);
         tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
         rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
         run_presses(count, cfg);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      $display("%0d ticks checked under %0d timing settings", board.checked, settings);
      $display("%0d relay toggles predicted, %0d on momentary release",
               board.toggles, board.momentary);
      if (board.errors == 0) begin
         $display("relay_bypass_footswitch_sequencer_core: match");
      end else begin
         $display("relay_bypass_footswitch_sequencer_core: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
hdl/rbfs_pkg.sv
hdl/rbfs_cfg.sv
hdl/rbfs_fsm.sv
hdl/relay_bypass_footswitch_sequencer_core.sv
bench/relay_bypass_footswitch_sequencer_core_tb.sv
